// File: rtl/gcdpf_pkg.sv
`timescale 1ns / 1ps

package gcdpf_pkg;

    // Width of the operand and result fields on the ports.
    localparam int unsigned FIELD_W = 32;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BOTH_LOW   = 3'd1,
        ST_FIRST_LOW  = 3'd2,
        ST_SECOND_LOW = 3'd3,
        ST_COPRIME    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] first_value;
        logic [FIELD_W-1:0] second_value;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] divisor;
        t_status            status;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic store;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;
        logic slot_free;
    } t_sts;

endpackage

// File: rtl/gcd_by_prime_factors.sv
`timescale 1ns / 1ps
// Each word is loaded, then reduced one binary-reduction step per cycle until the operands meet
//   or a low operand was flagged, then finished once the output register can take the result.
// Only one word is in flight: a new word is taken only after the previous one is finished.
// The next word is taken while the previous result still sits in the output register.
// Reset (synchronous, active low) returns the controller to idle and empties the output register.

module gcd_by_prime_factors #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gcdpf_pkg::t_in_word  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gcdpf_pkg::t_out_word o_out_data
);

    // Working width: operand bits above WIDTH are ignored, and the port fields
    // cap the width at their own size.
    localparam int unsigned DW = (WIDTH < gcdpf_pkg::FIELD_W) ? WIDTH : gcdpf_pkg::FIELD_W;

    gcdpf_pkg::t_cmd cmd;
    gcdpf_pkg::t_sts sts;

    // Controller: idle -> calc (reduce until operands match or a low operand
    // was flagged) -> finish (hold until the output register can take the word).
    gcdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: operand registers, count of shared factors of two, the
    // subtract-and-shift unit and the output register.
    gcdpf_dpath #(
        .DW (DW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/gcdpf_ctrl.sv
`timescale 1ns / 1ps

module gcdpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gcdpf_pkg::t_sts   i_sts,
    output gcdpf_pkg::t_cmd   o_cmd
);

    gcdpf_pkg::t_state r_state;
    gcdpf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcdpf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gcdpf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gcdpf_pkg::S_CALC;
                end
            end
            gcdpf_pkg::S_CALC: begin
                if (i_sts.done) begin
                    n_state = gcdpf_pkg::S_FINISH;
                end
            end
            gcdpf_pkg::S_FINISH: begin
                if (i_sts.slot_free) begin
                    n_state = gcdpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gcdpf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            gcdpf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            gcdpf_pkg::S_CALC: begin
                o_cmd.step = !i_sts.done;
            end
            gcdpf_pkg::S_FINISH: begin
                o_cmd.store = i_sts.slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/gcdpf_dpath.sv
`timescale 1ns / 1ps

module gcdpf_dpath #(
    parameter int unsigned DW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gcdpf_pkg::t_in_word  i_in_data,
    input  gcdpf_pkg::t_cmd      i_cmd,
    output gcdpf_pkg::t_sts      o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gcdpf_pkg::t_out_word o_out_data
);

    localparam int unsigned KW = $clog2(DW);

    logic [DW-1:0]        r_a;
    logic [DW-1:0]        r_b;
    logic [KW-1:0]        r_k;
    gcdpf_pkg::t_status   r_stat;
    logic                 r_out_valid;
    gcdpf_pkg::t_out_word r_out_data;

    logic [DW-1:0]        n_a;
    logic [DW-1:0]        n_b;
    logic [KW-1:0]        n_k;
    gcdpf_pkg::t_status   n_stat;

    logic [DW-1:0]        in_a;
    logic [DW-1:0]        in_b;
    logic                 a_low;
    logic                 b_low;
    logic [DW-1:0]        gcd_val;
    gcdpf_pkg::t_out_word fin_word;

    // Drop operand bits above the working width.
    assign in_a  = in_a_sel(i_in_data.first_value);
    assign in_b  = in_a_sel(i_in_data.second_value);
    assign a_low = (in_a[DW-1:1] == '0);
    assign b_low = (in_b[DW-1:1] == '0);

    function automatic logic [DW-1:0] in_a_sel(input logic [gcdpf_pkg::FIELD_W-1:0] v);
        logic [DW+gcdpf_pkg::FIELD_W-1:0] wide;
        wide     = (DW + gcdpf_pkg::FIELD_W)'(v);
        in_a_sel = wide[DW-1:0];
    endfunction

    // Load and screen the operands, then binary reduction: one shift or one subtract-and-shift per cycle.
    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_stat = r_stat;
        if (i_cmd.load) begin
            n_a = in_a;
            n_b = in_b;
            n_k = '0;
            if (a_low && b_low) begin
                n_stat = gcdpf_pkg::ST_BOTH_LOW;
            end else if (a_low) begin
                n_stat = gcdpf_pkg::ST_FIRST_LOW;
            end else if (b_low) begin
                n_stat = gcdpf_pkg::ST_SECOND_LOW;
            end else begin
                n_stat = gcdpf_pkg::ST_OK;
            end
        end else if (i_cmd.step) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + KW'(1);
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a > r_b) begin
                n_a = (r_a - r_b) >> 1;
            end else begin
                n_b = (r_b - r_a) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_k    <= n_k;
        r_stat <= n_stat;
    end

    // Restore the shared factors of two and classify.
    assign gcd_val = r_a << r_k;

    always_comb begin
        fin_word = '0;
        if (r_stat != gcdpf_pkg::ST_OK) begin
            fin_word.status = r_stat;
        end else if (gcd_val == DW'(1)) begin
            fin_word.status = gcdpf_pkg::ST_COPRIME;
        end else begin
            fin_word.status  = gcdpf_pkg::ST_OK;
            fin_word.divisor = gcdpf_pkg::FIELD_W'(gcd_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.store) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_out_data <= fin_word;
        end
    end

    assign o_sts.done      = (r_stat != gcdpf_pkg::ST_OK) || (r_a == r_b);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_stat == gcdpf_pkg::ST_OK) && (r_a != '0) && (r_b != '0))
        else $error("reduction step on a zero operand");

    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (!r_out_valid || i_out_ready))
        else $error("result stored over an unread word");

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status != gcdpf_pkg::ST_OK))
            |-> (r_out_data.divisor == '0))
        else $error("nonzero divisor with a fault status");

    a_ok_above_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status == gcdpf_pkg::ST_OK))
            |-> (r_out_data.divisor > gcdpf_pkg::FIELD_W'(1)))
        else $error("ok status with divisor below two");

endmodule

// File: sim/gcd_by_prime_factors_tb.sv
`timescale 1ns / 1ps

module gcd_by_prime_factors_tb;

    // Working width of the block and the resulting worst-case latency
    // (load, the reduction steps, finish).
    localparam int unsigned DUT_WIDTH       = 32;
    localparam int unsigned MAX_LATENCY     = 2 * DUT_WIDTH + 2;
    localparam int unsigned DRAIN_CYCLES    = 4 * MAX_LATENCY;
    // Cycles without any accepted word before the run is declared hung.
    localparam int unsigned STALL_LIMIT     = 4000;
    // Long receiver hold-off so that the block backs up into its input.
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned WORDS_PER_PHASE = 100;
    localparam int unsigned MAX_GAP         = 60;
    localparam int unsigned REPORT_MAX      = 10;
    localparam int unsigned NUM_PHASES      = 4;

    // Traffic shaping per phase, in percent of cycles.
    localparam int unsigned SEND_IDLE_PCT  [NUM_PHASES] = '{0, 74, 0, 22};
    localparam int unsigned RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 74, 22};

    // One row of the directed table: operands, whether the result is typed
    // in by hand, and that hand-typed result.
    typedef struct packed {
        gcdpf_pkg::t_in_word  operands;
        logic                 typed;
        gcdpf_pkg::t_out_word result;
    } t_dir_row;

    localparam int unsigned NUM_DIR = 20;
    localparam t_dir_row DIR_TAB [NUM_DIR] = '{
        // both operands low, every combination of 0 and 1
        '{'{32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h0, gcdpf_pkg::ST_BOTH_LOW}},
        '{'{32'h0000_0001, 32'h0000_0001}, 1'b1, '{32'h0, gcdpf_pkg::ST_BOTH_LOW}},
        '{'{32'h0000_0000, 32'h0000_0001}, 1'b1, '{32'h0, gcdpf_pkg::ST_BOTH_LOW}},
        '{'{32'h0000_0001, 32'h0000_0000}, 1'b1, '{32'h0, gcdpf_pkg::ST_BOTH_LOW}},
        // one operand low, the other at an extreme
        '{'{32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'h0, gcdpf_pkg::ST_FIRST_LOW}},
        '{'{32'h0000_0001, 32'h0000_0002}, 1'b1, '{32'h0, gcdpf_pkg::ST_FIRST_LOW}},
        '{'{32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{32'h0, gcdpf_pkg::ST_SECOND_LOW}},
        '{'{32'h0000_0002, 32'h0000_0001}, 1'b1, '{32'h0, gcdpf_pkg::ST_SECOND_LOW}},
        // equal operands, smallest and largest
        '{'{32'h0000_0002, 32'h0000_0002}, 1'b1, '{32'h0000_0002, gcdpf_pkg::ST_OK}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'hFFFF_FFFF, gcdpf_pkg::ST_OK}},
        // coprime: smallest pair and consecutive values at the top
        '{'{32'h0000_0002, 32'h0000_0003}, 1'b1, '{32'h0, gcdpf_pkg::ST_COPRIME}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFE}, 1'b1, '{32'h0, gcdpf_pkg::ST_COPRIME}},
        // powers of two and an even operand stress the shift path of a binary reduction
        '{'{32'h8000_0000, 32'h8000_0000}, 1'b1, '{32'h8000_0000, gcdpf_pkg::ST_OK}},
        '{'{32'h8000_0000, 32'h0000_0002}, 1'b1, '{32'h0000_0002, gcdpf_pkg::ST_OK}},
        '{'{32'hFFFF_FFFE, 32'h0000_0002}, 1'b1, '{32'h0000_0002, gcdpf_pkg::ST_OK}},
        // left to the predictor
        '{'{32'h0000_000C, 32'h0000_0012}, 1'b0, '{32'h0, gcdpf_pkg::ST_OK}},
        '{'{32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{32'h0, gcdpf_pkg::ST_OK}},
        '{'{32'hFFFF_FFFF, 32'h0000_FFFF}, 1'b0, '{32'h0, gcdpf_pkg::ST_OK}},
        '{'{32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '{32'h0, gcdpf_pkg::ST_OK}},
        '{'{32'hF000_0000, 32'h0F00_0000}, 1'b0, '{32'h0, gcdpf_pkg::ST_OK}}
    };

    // An accepted word and the result it must produce.
    typedef struct {
        gcdpf_pkg::t_in_word  operands;
        gcdpf_pkg::t_out_word result;
    } t_pending;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    gcdpf_pkg::t_in_word  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    gcdpf_pkg::t_out_word o_out_data;

    t_pending    pending_gcd_q [$];
    int unsigned mismatch_cnt   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_off_left  = 0;

    gcd_by_prime_factors #(
        .WIDTH(DUT_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predict the result for one operand pair: screen low operands first,
    // then reduce by remainders and flag a gcd of one as coprime.
    function automatic gcdpf_pkg::t_out_word gcd_of(gcdpf_pkg::t_in_word w);
        logic [DUT_WIDTH-1:0] a;
        logic [DUT_WIDTH-1:0] b;
        logic [DUT_WIDTH-1:0] r;
        gcdpf_pkg::t_out_word res;
        a = w.first_value[DUT_WIDTH-1:0];
        b = w.second_value[DUT_WIDTH-1:0];
        res.divisor = '0;
        if (a < 2 && b < 2) begin
            res.status = gcdpf_pkg::ST_BOTH_LOW;
        end else if (a < 2) begin
            res.status = gcdpf_pkg::ST_FIRST_LOW;
        end else if (b < 2) begin
            res.status = gcdpf_pkg::ST_SECOND_LOW;
        end else begin
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            if (a < 2) begin
                res.status = gcdpf_pkg::ST_COPRIME;
            end else begin
                res.status  = gcdpf_pkg::ST_OK;
                res.divisor = a;
            end
        end
        return res;
    endfunction

    // Draw an operand pair. Four draws in ten give a pair that shares a factor so
    // that the block reaches deep reductions; the rest cover low operands, coprime
    // neighbours, shifted random bits, equal pairs, small values and raw random bits.
    function automatic gcdpf_pkg::t_in_word random_operands();
        int unsigned         g;
        int unsigned         hi;
        gcdpf_pkg::t_in_word w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                g  = $urandom_range(2, 32'd1 << $urandom_range(2, 20));
                hi = 32'hFFFF_FFFF / g;
                w.first_value  = g * $urandom_range(1, hi);
                w.second_value = g * $urandom_range(1, hi);
            end
            4: begin
                w.first_value  = $urandom << $urandom_range(0, 31);
                w.second_value = $urandom << $urandom_range(0, 31);
            end
            5: begin
                w.first_value  = $urandom;
                w.second_value = $urandom;
            end
            6: begin
                w.first_value  = $urandom;
                w.second_value = w.first_value;
            end
            7: begin
                w.first_value  = $urandom;
                w.second_value = w.first_value + 1;
            end
            8: begin
                w.first_value  = $urandom;
                w.second_value = $urandom;
                case ($urandom_range(0, 2))
                    0: w.first_value  = $urandom_range(0, 1);
                    1: w.second_value = $urandom_range(0, 1);
                    default: begin
                        w.first_value  = $urandom_range(0, 1);
                        w.second_value = $urandom_range(0, 1);
                    end
                endcase
            end
            default: begin
                w.first_value  = $urandom_range(0, 300);
                w.second_value = $urandom_range(0, 300);
            end
        endcase
        return w;
    endfunction

    task automatic report_failure(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Offer one word, starting and ending at a falling edge. Drop valid for a
    // random gap first; otherwise keep it high straight from the last word.
    // Record the expected result at the edge that accepts the word.
    task automatic send_word(gcdpf_pkg::t_in_word w, gcdpf_pkg::t_out_word expected);
        int unsigned gap;
        t_pending    p;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p.operands = w;
        p.result   = expected;
        pending_gcd_q = {pending_gcd_q, p};
        @(negedge i_clk);
    endtask

    // Receiver: decide ready at the rising edge, drive it at the falling
    // edge. A pending hold-off wins over the random stall.
    initial begin : drive_out_ready
        logic next_ready;
        forever begin
            @(posedge i_clk);
            if (hold_off_left != 0) begin
                hold_off_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
            @(negedge i_clk);
            i_out_ready <= next_ready;
        end
    end

    // Compare every accepted result, field by field, with the oldest
    // expectation.
    initial begin : check_results
        t_pending p;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_gcd_q.size() == 0) begin
                    report_failure($sformatf("unexpected result divisor=%h status=%0d",
                                             o_out_data.divisor, o_out_data.status));
                end else begin
                    p = pending_gcd_q.pop_front();
                    if (o_out_data.divisor !== p.result.divisor ||
                        o_out_data.status !== p.result.status) begin
                        report_failure($sformatf(
                            "gcd(%h,%h): expected divisor=%h status=%0d, got divisor=%h status=%0d",
                            p.operands.first_value, p.operands.second_value,
                            p.result.divisor, p.result.status,
                            o_out_data.divisor, o_out_data.status));
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        gcdpf_pkg::t_in_word w;
        // Hold reset, then release it at a falling edge.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, no idling on either side.
        for (int i = 0; i < NUM_DIR; i++) begin
            send_word(DIR_TAB[i].operands,
                      DIR_TAB[i].typed ? DIR_TAB[i].result : gcd_of(DIR_TAB[i].operands));
        end

        // Random words, one traffic profile per phase.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            // Back up the output while the sender keeps offering at full rate.
            if (ph == 0) begin
                hold_off_left = HOLD_OFF_CYCLES;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                w = random_operands();
                send_word(w, gcd_of(w));
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then allow stray results to show up.
        recv_stall_pct = 0;
        while (pending_gcd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
